// ----- rtl/tmls_pkg.sv -----
// ----------------------------------------------------------------------------
// tmls_pkg
// Shared constants, register map codes and control structs for the texture
// mip layout stepper.
// ----------------------------------------------------------------------------
package tmls_pkg;

    // Walk limits
    localparam int MAX_DIM         = 16384;
    localparam int MAX_SLICES      = 2048;
    localparam int MAX_LEVELS      = 15;
    localparam int OFFSET_BITS_DEF = 40;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int BPP_W    = 8;
    localparam int DIM_W    = 15;
    localparam int DEPTH_W  = 12;
    localparam int CNT_W    = 12;
    localparam int LVL_W    = 4;
    localparam int SLC_W    = 11;
    localparam int BYTE40_W = 40;
    localparam int PITCH_W  = 19;

    // Internal datapath widths (exact products)
    localparam int ROW_W   = 20;
    localparam int BYTES_W = ROW_W + DIM_W;
    localparam int VOL_W   = BYTES_W + DEPTH_W;
    localparam int WIDE_W  = 65;

    // APB
    localparam int APB_DW = 64;
    localparam int APB_AW = 6;

    // Register indexes
    localparam logic [2:0] REG_BLOCK_MODE   = 3'd0;
    localparam logic [2:0] REG_BITS_PER_PIX = 3'd1;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd2;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd3;
    localparam logic [2:0] REG_IMAGE_DEPTH  = 3'd4;
    localparam logic [2:0] REG_SLICE_COUNT  = 3'd5;
    localparam logic [2:0] REG_LEVEL_COUNT  = 3'd6;
    localparam logic [2:0] REG_SIZE_LIMIT   = 3'd7;

    // Block modes
    localparam logic [MODE_W-1:0] BM_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] BM_BC8    = 2'd1;
    localparam logic [MODE_W-1:0] BM_BC16   = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]   block_mode;
        logic [BPP_W-1:0]    bits_per_pixel;
        logic [DIM_W-1:0]    image_width;
        logic [DIM_W-1:0]    image_height;
        logic [DEPTH_W-1:0]  image_depth;
        logic [CNT_W-1:0]    slice_count;
        logic [LVL_W-1:0]    level_count;
        logic [BYTE40_W-1:0] size_limit;
    } t_cfg;

    typedef struct packed {
        logic latch;     // capture request payload
        logic row_en;    // row pitch / row count stage
        logic bytes_en;  // bytes per depth slice stage
        logic vol_en;    // bytes times depth stage
        logic commit;    // update walk state, load result register
    } t_dp_cmd;

endpackage

// ----- rtl/tmls_regs.sv -----
// ----------------------------------------------------------------------------
// tmls_regs
// APB configuration registers, 64-bit data, register i at byte 8*i.
// ----------------------------------------------------------------------------
module tmls_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tmls_pkg::APB_AW-1:0]      paddr,
    input  logic [tmls_pkg::APB_DW-1:0]      pwdata,
    output logic [tmls_pkg::APB_DW-1:0]      prdata,
    output logic                             pready,
    output tmls_pkg::t_cfg                   o_cfg
);

    tmls_pkg::t_cfg r_cfg;
    logic [2:0]     w_idx;
    logic           w_wr;

    assign w_idx  = paddr[5:3];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_mode     <= tmls_pkg::BM_LINEAR;
            r_cfg.bits_per_pixel <= 8'd32;
            r_cfg.image_width    <= 15'd1;
            r_cfg.image_height   <= 15'd1;
            r_cfg.image_depth    <= 12'd1;
            r_cfg.slice_count    <= 12'd1;
            r_cfg.level_count    <= 4'd1;
            r_cfg.size_limit     <= 40'd0;
        end else if (w_wr) begin
            case (w_idx)
                tmls_pkg::REG_BLOCK_MODE:   r_cfg.block_mode     <= pwdata[1:0];
                tmls_pkg::REG_BITS_PER_PIX: r_cfg.bits_per_pixel <= pwdata[7:0];
                tmls_pkg::REG_IMAGE_WIDTH:  r_cfg.image_width    <= pwdata[14:0];
                tmls_pkg::REG_IMAGE_HEIGHT: r_cfg.image_height   <= pwdata[14:0];
                tmls_pkg::REG_IMAGE_DEPTH:  r_cfg.image_depth    <= pwdata[11:0];
                tmls_pkg::REG_SLICE_COUNT:  r_cfg.slice_count    <= pwdata[11:0];
                tmls_pkg::REG_LEVEL_COUNT:  r_cfg.level_count    <= pwdata[3:0];
                tmls_pkg::REG_SIZE_LIMIT:   r_cfg.size_limit     <= pwdata[39:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            tmls_pkg::REG_BLOCK_MODE:   prdata = 64'(r_cfg.block_mode);
            tmls_pkg::REG_BITS_PER_PIX: prdata = 64'(r_cfg.bits_per_pixel);
            tmls_pkg::REG_IMAGE_WIDTH:  prdata = 64'(r_cfg.image_width);
            tmls_pkg::REG_IMAGE_HEIGHT: prdata = 64'(r_cfg.image_height);
            tmls_pkg::REG_IMAGE_DEPTH:  prdata = 64'(r_cfg.image_depth);
            tmls_pkg::REG_SLICE_COUNT:  prdata = 64'(r_cfg.slice_count);
            tmls_pkg::REG_LEVEL_COUNT:  prdata = 64'(r_cfg.level_count);
            tmls_pkg::REG_SIZE_LIMIT:   prdata = 64'(r_cfg.size_limit);
            default:                    prdata = '0;
        endcase
    end

endmodule

// ----- rtl/tmls_ctrl.sv -----
// ----------------------------------------------------------------------------
// tmls_ctrl
// Sequencer: steps one request through the datapath stages and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module tmls_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output tmls_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROW   = 3'd1;
    localparam logic [2:0] ST_BYTES = 3'd2;
    localparam logic [2:0] ST_VOL   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_commit, w_accept;

    // Result register is free or being drained this cycle
    assign w_commit    = (r_state == ST_FIN) && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = !((r_state == ST_IDLE) || w_commit);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    assign o_cmd.latch    = w_accept;
    assign o_cmd.row_en   = (r_state == ST_ROW);
    assign o_cmd.bytes_en = (r_state == ST_BYTES);
    assign o_cmd.vol_en   = (r_state == ST_VOL);
    assign o_cmd.commit   = w_commit;

    always_comb begin
        case (r_state)
            ST_IDLE:  n_state = w_accept ? ST_ROW : ST_IDLE;
            ST_ROW:   n_state = ST_BYTES;
            ST_BYTES: n_state = ST_VOL;
            ST_VOL:   n_state = ST_FIN;
            ST_FIN:   n_state = w_commit ? (w_accept ? ST_ROW : ST_IDLE) : ST_FIN;
            default:  n_state = ST_IDLE;
        endcase
        n_out_valid = w_commit || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- rtl/tmls_dp.sv -----
// ----------------------------------------------------------------------------
// tmls_dp
// Layout datapath: walk state, staged size arithmetic with saturation and
// the result register.
// ----------------------------------------------------------------------------
module tmls_dp #(
    parameter int OFFSET_BITS = tmls_pkg::OFFSET_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tmls_pkg::t_cfg                    i_cfg,
    input  tmls_pkg::t_dp_cmd                 i_cmd,
    input  logic                              i_start_req,
    input  logic [tmls_pkg::BYTE40_W-1:0]     i_base_offset,
    output logic                              o_entry_valid,
    output logic [tmls_pkg::SLC_W-1:0]        o_slice_index,
    output logic [tmls_pkg::LVL_W-1:0]        o_level_index,
    output logic [tmls_pkg::BYTE40_W-1:0]     o_entry_offset,
    output logic [tmls_pkg::BYTE40_W-1:0]     o_level_bytes,
    output logic [tmls_pkg::PITCH_W-1:0]      o_row_pitch,
    output logic [tmls_pkg::BYTE40_W-1:0]     o_depth_pitch,
    output logic [tmls_pkg::BYTE40_W-1:0]     o_next_offset,
    output logic                              o_last,
    output logic                              o_overflow
);

    localparam int DW = tmls_pkg::DIM_W;
    localparam int XW = tmls_pkg::WIDE_W;
    localparam logic [XW-1:0] OFF_MAX_X = (XW'(1) << OFFSET_BITS) - XW'(1);
    localparam logic [DW-1:0] MAX_DIM_V = DW'(tmls_pkg::MAX_DIM);
    localparam logic [tmls_pkg::CNT_W-1:0] MAX_SLC_V = tmls_pkg::CNT_W'(tmls_pkg::MAX_SLICES);
    localparam logic [tmls_pkg::LVL_W-1:0] MAX_LVL_V = tmls_pkg::LVL_W'(tmls_pkg::MAX_LEVELS);
    localparam logic [tmls_pkg::ROW_W-1:0] PITCH_MAX = tmls_pkg::ROW_W'({tmls_pkg::PITCH_W{1'b1}});

    // Walk state
    logic [DW-1:0]                    r_cur_w, n_cur_w;
    logic [DW-1:0]                    r_cur_h, n_cur_h;
    logic [tmls_pkg::DEPTH_W-1:0]     r_cur_d, n_cur_d;
    logic [OFFSET_BITS-1:0]           r_run, n_run;
    logic [tmls_pkg::SLC_W-1:0]       r_slice, n_slice;
    logic [tmls_pkg::LVL_W-1:0]       r_level, n_level;
    logic                             r_active, n_active;

    // Request latch and stage registers
    logic                             r_start;
    logic [tmls_pkg::BYTE40_W-1:0]    r_base;
    logic [tmls_pkg::ROW_W-1:0]       r_row, n_row;
    logic [DW-1:0]                    r_rows, n_rows;
    logic [tmls_pkg::BYTES_W-1:0]     r_bytes;
    logic [tmls_pkg::VOL_W-1:0]       r_vol;
    logic                             r_bytes_big;
    logic [tmls_pkg::BYTE40_W-1:0]    r_lbytes;

    // Result register
    logic                             r_o_ev, n_o_ev;
    logic [tmls_pkg::SLC_W-1:0]       r_o_slc, n_o_slc;
    logic [tmls_pkg::LVL_W-1:0]       r_o_lvl, n_o_lvl;
    logic [tmls_pkg::BYTE40_W-1:0]    r_o_eoff, n_o_eoff;
    logic [tmls_pkg::BYTE40_W-1:0]    r_o_lb, n_o_lb;
    logic [tmls_pkg::PITCH_W-1:0]     r_o_rp, n_o_rp;
    logic [tmls_pkg::BYTE40_W-1:0]    r_o_dp, n_o_dp;
    logic [tmls_pkg::BYTE40_W-1:0]    r_o_noff, n_o_noff;
    logic                             r_o_last, n_o_last;
    logic                             r_o_ovf, n_o_ovf;

    logic                             w_bc;
    logic [DW+1:0]                    w_blk_w;
    logic [22:0]                      w_lin;
    logic                             w_bytes_big;
    logic [XW-1:0]                    w_vol_sat, w_sum, w_next, w_start_x;
    logic                             w_ovf, w_lvl_end, w_slc_end, w_fin;
    logic [tmls_pkg::CNT_W-1:0]       w_eff_slc;
    logic [tmls_pkg::LVL_W-1:0]       w_eff_lvl;
    logic [DW-1:0]                    w_load_w, w_load_h;

    // Row stage: bytes per row and number of (block) rows
    always_comb begin
        w_bc    = (i_cfg.block_mode == tmls_pkg::BM_BC8) ||
                  (i_cfg.block_mode == tmls_pkg::BM_BC16);
        w_blk_w = ((DW+2)'(r_cur_w) + (DW+2)'(3)) >> 2;
        w_lin   = 23'(r_cur_w) * 23'(i_cfg.bits_per_pixel) + 23'd7;
        if (w_bc) begin
            if (i_cfg.block_mode == tmls_pkg::BM_BC8) begin
                n_row = tmls_pkg::ROW_W'(w_blk_w) << 3;
            end else begin
                n_row = tmls_pkg::ROW_W'(w_blk_w) << 4;
            end
            n_rows = DW'(((DW+2)'(r_cur_h) + (DW+2)'(3)) >> 2);
        end else begin
            n_row  = tmls_pkg::ROW_W'(w_lin >> 3);
            n_rows = r_cur_h;
        end
    end

    assign w_bytes_big = (XW'(r_bytes) > OFF_MAX_X);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_start <= i_start_req;
            r_base  <= i_base_offset;
        end
        if (i_cmd.row_en) begin
            r_row  <= n_row;
            r_rows <= n_rows;
        end
        if (i_cmd.bytes_en) begin
            r_bytes <= tmls_pkg::BYTES_W'(r_row) * tmls_pkg::BYTES_W'(r_rows);
        end
        if (i_cmd.vol_en) begin
            r_vol       <= tmls_pkg::VOL_W'(r_bytes) * tmls_pkg::VOL_W'(r_cur_d);
            r_bytes_big <= w_bytes_big && (r_cur_d != '0);
            r_lbytes    <= w_bytes_big ? tmls_pkg::BYTE40_W'(OFF_MAX_X)
                                       : tmls_pkg::BYTE40_W'(r_bytes);
        end
    end

    // Commit: saturating offset sum, limit check, walk advance
    always_comb begin
        w_vol_sat = (r_bytes_big || (XW'(r_vol) > OFF_MAX_X)) ? OFF_MAX_X : XW'(r_vol);
        w_sum     = XW'(r_run) + w_vol_sat;
        w_next    = (w_sum > OFF_MAX_X) ? OFF_MAX_X : w_sum;
        w_ovf     = (i_cfg.size_limit != '0) && (w_next > XW'(i_cfg.size_limit));
        w_start_x = (XW'(r_base) > OFF_MAX_X) ? OFF_MAX_X : XW'(r_base);

        w_eff_slc = (i_cfg.slice_count > MAX_SLC_V) ? MAX_SLC_V : i_cfg.slice_count;
        w_eff_lvl = (i_cfg.level_count > MAX_LVL_V) ? MAX_LVL_V : i_cfg.level_count;
        w_lvl_end = ((tmls_pkg::LVL_W+1)'(r_level) + (tmls_pkg::LVL_W+1)'(1)) >=
                    (tmls_pkg::LVL_W+1)'(w_eff_lvl);
        w_slc_end = (tmls_pkg::CNT_W'(r_slice) + tmls_pkg::CNT_W'(1)) >= w_eff_slc;
        w_fin     = w_lvl_end && w_slc_end;

        w_load_w  = (i_cfg.image_width  > MAX_DIM_V) ? MAX_DIM_V : i_cfg.image_width;
        w_load_h  = (i_cfg.image_height > MAX_DIM_V) ? MAX_DIM_V : i_cfg.image_height;

        n_cur_w  = r_cur_w;
        n_cur_h  = r_cur_h;
        n_cur_d  = r_cur_d;
        n_run    = r_run;
        n_slice  = r_slice;
        n_level  = r_level;
        n_active = r_active;

        n_o_ev   = 1'b0;
        n_o_slc  = '0;
        n_o_lvl  = '0;
        n_o_eoff = '0;
        n_o_lb   = '0;
        n_o_rp   = '0;
        n_o_dp   = '0;
        n_o_noff = tmls_pkg::BYTE40_W'(r_run);
        n_o_last = 1'b0;
        n_o_ovf  = 1'b0;

        if (r_start) begin
            n_run    = w_start_x[OFFSET_BITS-1:0];
            n_slice  = '0;
            n_level  = '0;
            n_cur_w  = w_load_w;
            n_cur_h  = w_load_h;
            n_cur_d  = i_cfg.image_depth;
            n_active = (i_cfg.slice_count != '0) && (i_cfg.level_count != '0);
            n_o_noff = tmls_pkg::BYTE40_W'(w_start_x);
        end else if (r_active) begin
            n_o_ev   = 1'b1;
            n_o_slc  = r_slice;
            n_o_lvl  = r_level;
            n_o_eoff = tmls_pkg::BYTE40_W'(r_run);
            n_o_lb   = r_lbytes;
            n_o_rp   = tmls_pkg::PITCH_W'((r_row > PITCH_MAX) ? PITCH_MAX : r_row);
            n_o_dp   = r_lbytes;
            n_o_noff = tmls_pkg::BYTE40_W'(w_next);
            n_o_last = w_fin || w_ovf;
            n_o_ovf  = w_ovf;
            n_run    = w_next[OFFSET_BITS-1:0];
            if (w_fin || w_ovf) begin
                n_active = 1'b0;
            end else if (w_lvl_end) begin
                n_level = '0;
                n_slice = r_slice + 1'b1;
                n_cur_w = w_load_w;
                n_cur_h = w_load_h;
                n_cur_d = i_cfg.image_depth;
            end else begin
                n_level = r_level + 1'b1;
                n_cur_w = (r_cur_w > DW'(1)) ? (r_cur_w >> 1) : DW'(1);
                n_cur_h = (r_cur_h > DW'(1)) ? (r_cur_h >> 1) : DW'(1);
                n_cur_d = (r_cur_d > 12'd1) ? (r_cur_d >> 1) : 12'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_w  <= '0;
            r_cur_h  <= '0;
            r_cur_d  <= '0;
            r_run    <= '0;
            r_slice  <= '0;
            r_level  <= '0;
            r_active <= 1'b0;
        end else if (i_cmd.commit) begin
            r_cur_w  <= n_cur_w;
            r_cur_h  <= n_cur_h;
            r_cur_d  <= n_cur_d;
            r_run    <= n_run;
            r_slice  <= n_slice;
            r_level  <= n_level;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_ev   <= n_o_ev;
            r_o_slc  <= n_o_slc;
            r_o_lvl  <= n_o_lvl;
            r_o_eoff <= n_o_eoff;
            r_o_lb   <= n_o_lb;
            r_o_rp   <= n_o_rp;
            r_o_dp   <= n_o_dp;
            r_o_noff <= n_o_noff;
            r_o_last <= n_o_last;
            r_o_ovf  <= n_o_ovf;
        end
    end

    assign o_entry_valid  = r_o_ev;
    assign o_slice_index  = r_o_slc;
    assign o_level_index  = r_o_lvl;
    assign o_entry_offset = r_o_eoff;
    assign o_level_bytes  = r_o_lb;
    assign o_row_pitch    = r_o_rp;
    assign o_depth_pitch  = r_o_dp;
    assign o_next_offset  = r_o_noff;
    assign o_last         = r_o_last;
    assign o_overflow     = r_o_ovf;

endmodule

// ----- rtl/texture_mip_layout_stepper_core.sv -----
// ----------------------------------------------------------------------------
// texture_mip_layout_stepper_core
// Walks a texture's subresource layout, one subresource per request.
// ----------------------------------------------------------------------------
// Usage:
//   Program the format, top-level size, slice/level counts and size limit
//   over APB (64-bit data, register i at byte 8*i) while the block is idle.
//   Send a request with start_req=1 and a base offset to begin a walk; each
//   following request with start_req=0 returns one subresource (slice-major,
//   level-minor) with its offset, sizes, pitches and the running offset.
//   The result flagged last ends the walk; overflow also sets last.
// Sequence:
//   A request goes from acceptance to its result in the output register
//   through row pitch, bytes per slice, bytes times depth, then the
//   saturating offset add and commit. The next request is accepted on the
//   commit cycle, so only one request is in work at a time.
// Reset (synchronous, active low): registers return to defaults, the walk
//   is idle and the running offset is zero.
// Stall: a result waits in the output register while i_out_stall is high;
//   the next request still runs up to its commit and holds there until the
//   output register frees.
// ----------------------------------------------------------------------------
module texture_mip_layout_stepper_core #(
    parameter int OFFSET_BITS = tmls_pkg::OFFSET_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tmls_pkg::APB_AW-1:0]       paddr,
    input  logic [tmls_pkg::APB_DW-1:0]       pwdata,
    output logic [tmls_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    // Request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_start_req,
    input  logic [tmls_pkg::BYTE40_W-1:0]     i_base_offset,
    // Result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_entry_valid,
    output logic [tmls_pkg::SLC_W-1:0]        o_slice_index,
    output logic [tmls_pkg::LVL_W-1:0]        o_level_index,
    output logic [tmls_pkg::BYTE40_W-1:0]     o_entry_offset,
    output logic [tmls_pkg::BYTE40_W-1:0]     o_level_bytes,
    output logic [tmls_pkg::PITCH_W-1:0]      o_row_pitch,
    output logic [tmls_pkg::BYTE40_W-1:0]     o_depth_pitch,
    output logic [tmls_pkg::BYTE40_W-1:0]     o_next_offset,
    output logic                              o_last,
    output logic                              o_overflow
);

    tmls_pkg::t_cfg    w_cfg;
    tmls_pkg::t_dp_cmd w_cmd;

    // Configuration registers; contents are live to the datapath
    tmls_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer: idle -> row -> bytes -> vol -> fin (commit)
    tmls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    // Size arithmetic, walk state and result register
    tmls_dp #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_cmd          (w_cmd),
        .i_start_req    (i_start_req),
        .i_base_offset  (i_base_offset),
        .o_entry_valid  (o_entry_valid),
        .o_slice_index  (o_slice_index),
        .o_level_index  (o_level_index),
        .o_entry_offset (o_entry_offset),
        .o_level_bytes  (o_level_bytes),
        .o_row_pitch    (o_row_pitch),
        .o_depth_pitch  (o_depth_pitch),
        .o_next_offset  (o_next_offset),
        .o_last         (o_last),
        .o_overflow     (o_overflow)
    );

    logic w_in_acc;
    assign w_in_acc = i_in_valid && !o_in_stall;

    // One request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("request accepted while previous one still in work");

    // A result appearing in an empty output register stems from the request
    // accepted before it stepped through the row, bytes, vol and fin states
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_in_acc, 5))
        else $error("result without matching request");

    // Overflow always closes a real subresource entry
    a_ovf_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow) |-> (o_last && o_entry_valid))
        else $error("overflow without last entry");

endmodule
